// ===== hw/rtl/rgb_to_hsl_converter_assert.svh =====
// assertion macros for the rgb to hsl converter
`ifndef RGB_TO_HSL_CONVERTER_ASSERT_SVH
`define RGB_TO_HSL_CONVERTER_ASSERT_SVH

// fixed delay between a trigger and an expected event
`define RGBHSL_ASSERT_DELAY(label, clk, rst_n, trig, n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> ##n (expr)) \
        else $error("rgbhsl: delayed check failed");

// same-cycle implication
`define RGBHSL_ASSERT_IMPLY(label, clk, rst_n, trig, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (expr)) \
        else $error("rgbhsl: implication check failed");

`endif

// ===== hw/rtl/rgbhsl_pkg.sv =====
package rgbhsl_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CH_W      = 8;
    localparam int SUM_W     = 9;
    localparam int FIELD_W   = 16;
    localparam int DEN_W     = 11;
    // front end takes two stages, divider one per fraction bit, then the output register
    localparam int LATENCY   = FRAC_BITS + 3;

    typedef enum logic [2:0] {
        SECT_RED   = 3'b001,
        SECT_GREEN = 3'b010,
        SECT_BLUE  = 3'b100
    } sector_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } pixel_t;

    typedef struct packed {
        logic [FIELD_W-1:0] hue_frac;
        logic [FIELD_W-1:0] saturation_frac;
        logic [SUM_W-1:0]   lightness_sum;
        logic [CH_W-1:0]    alpha_out;
    } hsl_t;

    // one division job, num below den unless full is set
    typedef struct packed {
        logic [DEN_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             full;
    } div_in_t;

    typedef struct packed {
        logic [DEN_W-1:0]     rem;
        logic [DEN_W-1:0]     den;
        logic [FRAC_BITS-1:0] quo;
        logic                 full;
    } div_t;

    typedef struct packed {
        div_in_t          hue;
        div_in_t          sat;
        logic [SUM_W-1:0] lightness;
        logic [CH_W-1:0]  alpha;
    } front_t;

    // fit a FRAC_BITS quotient to the output field, keeping the low bits
    function automatic logic [FIELD_W-1:0] fit_field(input logic [FRAC_BITS-1:0] q);
        logic [FRAC_BITS+FIELD_W-1:0] wide;
        wide = {{FIELD_W{1'b0}}, q};
        return wide[FIELD_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/rgbhsl_front.sv =====
module rgbhsl_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pix_valid,
    input  rgbhsl_pkg::pixel_t  pixel,
    output logic                stage_valid,
    output rgbhsl_pkg::front_t  front
);
    import rgbhsl_pkg::*;

    // stage a: extremes and sector
    logic              a_valid_reg;
    pixel_t            a_pix_reg;
    logic [CH_W-1:0]   a_max_reg;
    logic [CH_W-1:0]   a_min_reg;
    sector_t           a_sect_reg;

    logic [CH_W-1:0]   max_next;
    logic [CH_W-1:0]   min_next;
    sector_t           sect_next;

    always_comb
    begin
        if (pixel.blue >= pixel.red && pixel.blue >= pixel.green)
        begin
            sect_next = SECT_BLUE;
            max_next  = pixel.blue;
        end
        else if (pixel.green >= pixel.red)
        begin
            sect_next = SECT_GREEN;
            max_next  = pixel.green;
        end
        else
        begin
            sect_next = SECT_RED;
            max_next  = pixel.red;
        end
        min_next = pixel.red;
        if (pixel.green < min_next)
            min_next = pixel.green;
        if (pixel.blue < min_next)
            min_next = pixel.blue;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= pix_valid;
    end

    always_ff @(posedge clk)
    begin
        a_pix_reg  <= pixel;
        a_max_reg  <= max_next;
        a_min_reg  <= min_next;
        a_sect_reg <= sect_next;
    end

    // stage b: difference, sum and the two division jobs
    logic             b_valid_reg;
    front_t           b_front_reg;
    front_t           front_next;

    logic [DEN_W-1:0] d11;
    logic [DEN_W-1:0] r11;
    logic [DEN_W-1:0] g11;
    logic [DEN_W-1:0] b11;
    logic [SUM_W-1:0] sum9;
    logic [SUM_W-1:0] den9;

    always_comb
    begin
        d11  = {{(DEN_W-CH_W){1'b0}}, a_max_reg - a_min_reg};
        r11  = {{(DEN_W-CH_W){1'b0}}, a_pix_reg.red};
        g11  = {{(DEN_W-CH_W){1'b0}}, a_pix_reg.green};
        b11  = {{(DEN_W-CH_W){1'b0}}, a_pix_reg.blue};
        sum9 = {1'b0, a_max_reg} + {1'b0, a_min_reg};
        den9 = (sum9 > SUM_W'(255)) ? SUM_W'(510) - sum9 : sum9;

        front_next.lightness = sum9;
        front_next.alpha     = a_pix_reg.alpha;

        case (a_sect_reg)
            SECT_BLUE:  front_next.hue.num = (d11 << 2) + r11 - g11;
            SECT_GREEN: front_next.hue.num = (d11 << 1) + b11 - r11;
            SECT_RED:
            begin
                if (g11 < b11)
                    front_next.hue.num = (d11 << 2) + (d11 << 1) - (b11 - g11);
                else
                    front_next.hue.num = g11 - b11;
            end
            default:    front_next.hue.num = '0;
        endcase
        front_next.hue.den  = (d11 << 2) + (d11 << 1);
        front_next.hue.full = 1'b0;

        front_next.sat.num  = d11;
        front_next.sat.den  = {{(DEN_W-SUM_W){1'b0}}, den9};
        front_next.sat.full = (d11 == front_next.sat.den);

        // grey pixel: both fractions come out as zero
        if (d11 == '0)
        begin
            front_next.hue.num  = '0;
            front_next.hue.den  = DEN_W'(1);
            front_next.sat.num  = '0;
            front_next.sat.den  = DEN_W'(1);
            front_next.sat.full = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        b_front_reg <= front_next;
    end

    assign stage_valid = b_valid_reg;
    assign front       = b_front_reg;

endmodule

// ===== hw/rtl/rgbhsl_div_step.sv =====
module rgbhsl_div_step (
    input  logic               clk,
    input  rgbhsl_pkg::div_t   cur,
    output rgbhsl_pkg::div_t   nxt
);
    import rgbhsl_pkg::*;

    logic [DEN_W:0] shifted;
    logic [DEN_W:0] diff;
    logic           ge;
    div_t           step_next;
    div_t           step_reg;

    always_comb
    begin
        shifted            = {cur.rem, 1'b0};
        diff               = shifted - {1'b0, cur.den};
        ge                 = (shifted >= {1'b0, cur.den});
        step_next.rem      = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        step_next.den      = cur.den;
        step_next.quo      = {cur.quo[FRAC_BITS-2:0], ge};
        step_next.full     = cur.full;
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
    end

    assign nxt = step_reg;

endmodule

// ===== hw/rtl/rgbhsl_divider.sv =====
module rgbhsl_divider (
    input  logic                              clk,
    input  rgbhsl_pkg::div_in_t               job,
    output logic [rgbhsl_pkg::FIELD_W-1:0]    quotient
);
    import rgbhsl_pkg::*;

    div_t chain [FRAC_BITS+1];

    // a full job yields all ones, so its remainder is parked at zero
    always_comb
    begin
        chain[0].rem  = job.full ? '0 : job.num;
        chain[0].den  = job.den;
        chain[0].quo  = '0;
        chain[0].full = job.full;
    end

    for (genvar i = 0; i < FRAC_BITS; i++)
    begin : g_step
        rgbhsl_div_step u_step (
            .clk (clk),
            .cur (chain[i]),
            .nxt (chain[i+1])
        );
    end

    assign quotient = fit_field(chain[FRAC_BITS].full ? {FRAC_BITS{1'b1}}
                                                      : chain[FRAC_BITS].quo);

endmodule

// ===== hw/rtl/rgb_to_hsl_converter.sv =====
// rgb to hsl converter, one 8-bit rgba pixel in, its hsl form out
//
// input channel: drive pixel and raise start for one cycle; the word is taken
// at the rising edge where start is high and busy is low. busy is held low,
// so a new pixel can be offered in every cycle.
// output channel: done pulses for one cycle with result valid alongside;
// the receiver must take it then, there is no way to hold results off.
//
// path: from accept to done a pixel passes two front-end stages, one divider
// stage per fraction bit and the output register. throughput: one pixel per
// cycle, the hue and saturation dividers are fully pipelined restoring
// dividers of one bit per stage.
//
// reset: rst_n clears every valid bit at once, so no done pulse appears for
// words that were in flight; the data path itself is not reset.
// results leave in the order the pixels came in.
module rgb_to_hsl_converter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  rgbhsl_pkg::pixel_t  pixel,
    output logic                done,
    output rgbhsl_pkg::hsl_t    result
);
    import rgbhsl_pkg::*;

`include "rgb_to_hsl_converter_assert.svh"

    // sideband carried alongside the divider stages
    typedef struct packed {
        logic [SUM_W-1:0] lightness;
        logic [CH_W-1:0]  alpha;
    } side_t;

    logic                 front_valid;
    front_t               front;
    logic [FIELD_W-1:0]   hue_q;
    logic [FIELD_W-1:0]   sat_q;

    logic                 vld_reg  [FRAC_BITS];
    side_t                side_reg [FRAC_BITS];

    logic                 done_reg;
    hsl_t                 result_reg;
    hsl_t                 result_next;

    // nothing ever blocks the pipeline
    assign busy = 1'b0;

    // max, min, sector and the division jobs
    rgbhsl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix_valid   (start && !busy),
        .pixel       (pixel),
        .stage_valid (front_valid),
        .front       (front)
    );

    // hue: num / (6 d)
    rgbhsl_divider u_hue_div (
        .clk      (clk),
        .job      (front.hue),
        .quotient (hue_q)
    );

    // saturation: d / s or d / (510 - s)
    rgbhsl_divider u_sat_div (
        .clk      (clk),
        .job      (front.sat),
        .quotient (sat_q)
    );

    // valid bits and sideband follow the divider depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAC_BITS; i++)
                vld_reg[i] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= front_valid;
            for (int i = 1; i < FRAC_BITS; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0].lightness <= front.lightness;
        side_reg[0].alpha     <= front.alpha;
        for (int i = 1; i < FRAC_BITS; i++)
            side_reg[i] <= side_reg[i-1];
    end

    // output register: the result word is shown for exactly one cycle
    always_comb
    begin
        result_next.hue_frac        = hue_q;
        result_next.saturation_frac = sat_q;
        result_next.lightness_sum   = side_reg[FRAC_BITS-1].lightness;
        result_next.alpha_out       = side_reg[FRAC_BITS-1].alpha;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_reg[FRAC_BITS-1];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // every accepted word comes out after the fixed latency
    `RGBHSL_ASSERT_DELAY(a_latency, clk, rst_n, start && !busy, LATENCY, done)
    // alpha rides along untouched
    `RGBHSL_ASSERT_IMPLY(a_alpha, clk, rst_n, done,
        result.alpha_out == $past(pixel.alpha, LATENCY))
    // a coloured pixel with any hue also has non-zero saturation
    `RGBHSL_ASSERT_IMPLY(a_hue_sat, clk, rst_n, done && result.hue_frac != '0,
        result.saturation_frac != '0)

endmodule

// ===== test/tb_rgb_to_hsl_converter.sv =====
`timescale 1ns / 1ps

// self-checking bench for the rgb to hsl converter
module tb_rgb_to_hsl_converter;
    import rgbhsl_pkg::*;

    // cycle budget: ~530 words with their random gaps, plus latency and the
    // drains, fits well inside CYCLE_LIMIT
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = LATENCY + 8;
    localparam int RANDOM_WORDS  = 500;
    localparam int REPORT_LIMIT  = 10;
    localparam int N_ROWS        = 24;

    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    pixel_t pixel;
    logic   done;
    hsl_t   result;

    rgb_to_hsl_converter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .pixel  (pixel),
        .done   (done),
        .result (result)
    );

    // one row of the directed table: pixel as 0xRRGGBBAA, and the hsl word
    // typed in by hand where known is set, otherwise left to the predictor
    typedef struct {
        pixel_t px;
        bit     known;
        hsl_t   want;
    } pixel_row_t;

    // hsl word layout: {hue_frac, saturation_frac, lightness_sum, alpha_out}
    pixel_row_t dir_rows [N_ROWS] = '{
        // grey pixels: hue and saturation forced to zero, alpha still carried
        '{32'h00000000, 1'b1, {16'd0, 16'd0, 9'd0, 8'h00}},
        '{32'hFFFFFFFF, 1'b1, {16'd0, 16'd0, 9'd510, 8'hFF}},
        '{32'h808080A5, 1'b1, {16'd0, 16'd0, 9'd256, 8'hA5}},
        '{32'h0101015A, 1'b1, {16'd0, 16'd0, 9'd2, 8'h5A}},
        // primaries: full saturation clamps to all ones
        '{32'hFF00003C, 1'b1, {16'd0, 16'd65535, 9'd255, 8'h3C}},
        '{32'h00FF00C3, 1'b1, {16'd21845, 16'd65535, 9'd255, 8'hC3}},
        '{32'h0000FF81, 1'b1, {16'd43690, 16'd65535, 9'd255, 8'h81}},
        // smallest spread, at both ends of the lightness range
        '{32'h0100007E, 1'b1, {16'd0, 16'd65535, 9'd1, 8'h7E}},
        '{32'hFFFEFE00, 1'b1, {16'd0, 16'd65535, 9'd509, 8'h00}},
        // ties for largest: blue beats green, green beats red
        '{32'hFFFF0011, 1'b0, '0},
        '{32'hFF00FF22, 1'b0, '0},
        '{32'h00FFFF44, 1'b0, '0},
        '{32'h7FFFFF99, 1'b0, '0},
        // red largest: green below blue wraps round by a full turn, green above blue does not
        '{32'hFF000166, 1'b0, '0},
        '{32'hFF0100EE, 1'b0, '0},
        '{32'h80007F01, 1'b0, '0},
        // light and dark halves of the saturation divisor
        '{32'hFFC86480, 1'b0, '0},
        '{32'h0A050040, 1'b0, '0},
        '{32'h10203088, 1'b0, '0},
        '{32'h7F8081F0, 1'b0, '0},
        '{32'h01020377, 1'b0, '0},
        '{32'hFEFFFD0F, 1'b0, '0},
        '{32'hC0C0BFAA, 1'b0, '0},
        '{32'h00FF8055, 1'b0, '0}
    };

    hsl_t hsl_due_q [$];
    int   mismatches;
    int   cycle_count;

    // floor of num/den in FRAC_BITS fraction bits, clamped at all ones,
    // then cut down to the output field
    function automatic logic [FIELD_W-1:0] fixed_fraction(longint unsigned num,
                                                          longint unsigned den);
        longint unsigned q;
        longint unsigned top;
        top = (64'd1 << FRAC_BITS) - 1;
        if (den == 0)
            return '0;
        q = (num << FRAC_BITS) / den;
        if (q > top)
            q = top;
        return q[FIELD_W-1:0];
    endfunction

    // expected hsl word for one pixel
    function automatic hsl_t hsl_of_pixel(pixel_t p);
        longint unsigned r, g, b;
        longint unsigned top, bottom, spread, sum, den, num;
        sector_t         sector;
        hsl_t            h;
        r = p.red;
        g = p.green;
        b = p.blue;
        top    = (r > g) ? r : g;
        top    = (b > top) ? b : top;
        bottom = (r < g) ? r : g;
        bottom = (b < bottom) ? b : bottom;
        spread = top - bottom;
        sum    = top + bottom;
        h = '0;
        h.lightness_sum = sum[SUM_W-1:0];
        h.alpha_out     = p.alpha;
        if (spread != 0)
        begin
            // saturation divides by the distance to the nearer end of the range
            den = (sum > 255) ? 510 - sum : sum;
            h.saturation_frac = fixed_fraction(spread, den);
            // tie-break order: blue, then green, then red
            if (b == top)
                sector = SECT_BLUE;
            else if (g == top)
                sector = SECT_GREEN;
            else
                sector = SECT_RED;
            case (sector)
                SECT_BLUE:  num = 4 * spread + r - g;
                SECT_GREEN: num = 2 * spread + b - r;
                default:    num = (g < b) ? 6 * spread - (b - g) : g - b;
            endcase
            h.hue_frac = fixed_fraction(num, 6 * spread);
        end
        return h;
    endfunction

    // random pixel, leaning on greys, ties and channel extremes
    function automatic pixel_t random_pixel();
        pixel_t          p;
        int              v;
        int              lo;
        logic [CH_W-1:0] hi8;
        logic [CH_W-1:0] lo8;
        p = $urandom;
        case ($urandom_range(0, 9))
            0:
            begin
                p.green = p.red;
                p.blue  = p.red;
            end
            1:
            begin
                v   = $urandom_range(1, 255);
                lo  = $urandom_range(0, v - 1);
                hi8 = CH_W'(v);
                lo8 = CH_W'(lo);
                case ($urandom_range(0, 2))
                    0:
                    begin
                        p.red   = hi8;
                        p.green = hi8;
                        p.blue  = lo8;
                    end
                    1:
                    begin
                        p.red   = hi8;
                        p.blue  = hi8;
                        p.green = lo8;
                    end
                    default:
                    begin
                        p.green = hi8;
                        p.blue  = hi8;
                        p.red   = lo8;
                    end
                endcase
            end
            2:
            begin
                p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                p.green = $urandom_range(0, 3) == 0 ? 8'h01
                                                    : ($urandom_range(0, 1) ? 8'hFF : 8'h00);
                p.blue  = $urandom_range(0, 3) == 0 ? 8'hFE
                                                    : ($urandom_range(0, 1) ? 8'hFF : 8'h00);
            end
            default: ;
        endcase
        return p;
    endfunction

    // mostly back to back or short gaps, now and then a long one
    function automatic int random_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // offer one word and hold it until the converter takes it
    task automatic send_word(pixel_t p, hsl_t want);
        pixel <= p;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        hsl_due_q = {hsl_due_q, want};
    endtask

    // drop start for a while, with junk on the pixel bus that must be ignored
    task automatic idle_for(int n);
        if (n > 0)
        begin
            start <= 1'b0;
            pixel <= $urandom;
            repeat (n)
                @(posedge clk);
        end
    endtask

    // stop sending until every outstanding word has come back
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (hsl_due_q.size() != 0);
    endtask

    task automatic note_mismatch(string field, longint unsigned want, longint unsigned got);
        if (mismatches < REPORT_LIMIT)
            $display("mismatch on %s: expected %0d, got %0d", field, want, got);
        mismatches++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // result side: done is a one-cycle strobe, compared against the oldest
    // expected word, field by field
    always @(posedge clk)
    begin
        hsl_t want;
        if (rst_n && done)
        begin
            if (hsl_due_q.size() == 0)
            begin
                if (mismatches < REPORT_LIMIT)
                    $display("result word with nothing expected: %h", result);
                mismatches++;
            end
            else
            begin
                want = hsl_due_q.pop_front();
                if (result.hue_frac !== want.hue_frac)
                    note_mismatch("hue_frac", want.hue_frac, result.hue_frac);
                if (result.saturation_frac !== want.saturation_frac)
                    note_mismatch("saturation_frac", want.saturation_frac,
                                  result.saturation_frac);
                if (result.lightness_sum !== want.lightness_sum)
                    note_mismatch("lightness_sum", want.lightness_sum, result.lightness_sum);
                if (result.alpha_out !== want.alpha_out)
                    note_mismatch("alpha_out", want.alpha_out, result.alpha_out);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        hsl_t want;
        int   gap;
        mismatches  = 0;
        cycle_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        pixel = '0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, hand-typed results where they are obvious
        foreach (dir_rows[i])
        begin
            want = dir_rows[i].known ? dir_rows[i].want : hsl_of_pixel(dir_rows[i].px);
            send_word(dir_rows[i].px, want);
            idle_for((i % 3 == 2) ? random_gap() : 0);
        end

        // let the pipeline empty completely before the random part
        drain_results();

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            pixel_t p;
            p = random_pixel();
            send_word(p, hsl_of_pixel(p));
            // every fourth block of 32 words goes back to back
            gap = ((i / 32) % 4 == 1) ? 0 : random_gap();
            if (i == RANDOM_WORDS / 2)
                drain_results();
            else
                idle_for(gap);
        end

        // wait for the last words, then a little longer for any stray strobe
        start <= 1'b0;
        while (hsl_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== rgb_to_hsl_converter.f =====
+incdir+hw/rtl
hw/rtl/rgbhsl_pkg.sv
hw/rtl/rgbhsl_front.sv
hw/rtl/rgbhsl_div_step.sv
hw/rtl/rgbhsl_divider.sv
hw/rtl/rgb_to_hsl_converter.sv
test/tb_rgb_to_hsl_converter.sv
